>>> src/lusc_pkg.sv
package lusc_pkg;

	localparam int LUSC_NUM_REGS     = 32;
	localparam int LUSC_MAX_OPERANDS = 3;
	localparam int LUSC_COUNT_BITS   = 48;

	localparam int OPND_BITS   = 5;
	localparam int OPND_FIELDS = 3;
	localparam int CNT_BITS    = 2;
	localparam int REPEAT_BITS = 32;
	localparam int OUT_BITS    = 48;

	localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};

	typedef struct packed {
		logic                   start_of_run;
		logic                   is_load;
		logic                   is_memory;
		logic [CNT_BITS-1:0]    operand_count;
		logic [OPND_BITS-1:0]   operand_a;
		logic [OPND_BITS-1:0]   operand_b;
		logic [OPND_BITS-1:0]   operand_c;
		logic [REPEAT_BITS-1:0] block_repeat;
		logic                   last_in_block;
	} lusc_in_t;

	typedef struct packed {
		logic                block_stalled;
		logic [OUT_BITS-1:0] cycles_without_stalls;
		logic [OUT_BITS-1:0] stall_cycles;
		logic [OUT_BITS-1:0] total_cycles;
	} lusc_out_t;

	// stage to core: one registered instruction and whether it moves this cycle
	typedef struct packed {
		logic     go;
		lusc_in_t item;
	} lusc_stage_t;

endpackage

>>> src/lusc_in_stage.sv
module lusc_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  lusc_pkg::lusc_in_t item,
	input  logic              out_free,
	output lusc_pkg::lusc_stage_t stage
);
	import lusc_pkg::*;

	logic     valid_s1;
	lusc_in_t item_s1;
	logic     advance;

	// a non-terminal instruction never needs the output slot
	assign advance    = !item_s1.last_in_block || out_free;
	assign item_ready = !valid_s1 || advance;

	assign stage.go   = valid_s1 && advance;
	assign stage.item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

endmodule

>>> src/lusc_core.sv
module lusc_core #(
	parameter int NUM_REGS     = lusc_pkg::LUSC_NUM_REGS,
	parameter int MAX_OPERANDS = lusc_pkg::LUSC_MAX_OPERANDS,
	parameter int COUNT_BITS   = lusc_pkg::LUSC_COUNT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lusc_pkg::lusc_stage_t stage,
	output logic                  res_valid,
	output lusc_pkg::lusc_out_t   res
);
	import lusc_pkg::*;

	logic [NUM_REGS-1:0]   prev_mask_q;
	logic [NUM_REGS-1:0]   cur_mask_q;
	logic                  stall_q;
	logic [COUNT_BITS-1:0] plain_q;
	logic [COUNT_BITS-1:0] stall_sum_q;

	logic [NUM_REGS-1:0]   base_prev;
	logic [NUM_REGS-1:0]   base_cur;
	logic                  base_stall;
	logic [COUNT_BITS-1:0] base_plain;
	logic [COUNT_BITS-1:0] base_ssum;

	logic [OPND_BITS-1:0]  opnd [OPND_FIELDS];
	logic [NUM_REGS-1:0]   use_mask;
	logic                  stall_new;
	logic [NUM_REGS-1:0]   cur_new;
	logic [COUNT_BITS:0]   plain_add;
	logic [COUNT_BITS:0]   ssum_add;
	logic [COUNT_BITS-1:0] plain_new;
	logic [COUNT_BITS-1:0] ssum_new;
	logic [63:0]           plain_w;
	logic [63:0]           ssum_w;
	logic [OUT_BITS-1:0]   plain_out;
	logic [OUT_BITS-1:0]   ssum_out;
	logic [OUT_BITS:0]     total_add;

	lusc_in_t it;
	assign it = stage.item;

	assign base_prev  = it.start_of_run ? '0 : prev_mask_q;
	assign base_cur   = it.start_of_run ? '0 : cur_mask_q;
	assign base_stall = it.start_of_run ? 1'b0 : stall_q;
	assign base_plain = it.start_of_run ? '0 : plain_q;
	assign base_ssum  = it.start_of_run ? '0 : stall_sum_q;

	assign opnd[0] = it.operand_a;
	assign opnd[1] = it.operand_b;
	assign opnd[2] = it.operand_c;

	// registers named by the valid operands; numbers of NUM_REGS and above drop out
	always_comb begin
		use_mask = '0;
		for (int i = 0; i < OPND_FIELDS; i++) begin
			if (i < MAX_OPERANDS && 32'(i) < 32'(it.operand_count)) begin
				for (int r = 0; r < NUM_REGS; r++) begin
					if (r < (1 << OPND_BITS) && opnd[i] == OPND_BITS'(r)) begin
						use_mask[r] = 1'b1;
					end
				end
			end
		end
	end

	assign stall_new = base_stall || (!it.is_memory && |(use_mask & base_prev));
	assign cur_new   = base_cur | (it.is_load ? use_mask : '0);

	assign plain_add = {1'b0, base_plain} + (COUNT_BITS+1)'(it.block_repeat);
	assign ssum_add  = {1'b0, base_ssum} + (COUNT_BITS+1)'(it.block_repeat);
	assign plain_new = plain_add[COUNT_BITS] ? '1 : plain_add[COUNT_BITS-1:0];
	assign ssum_new  = !stall_new ? base_ssum :
		(ssum_add[COUNT_BITS] ? '1 : ssum_add[COUNT_BITS-1:0]);

	assign plain_w   = 64'(plain_new);
	assign ssum_w    = 64'(ssum_new);
	assign plain_out = (plain_w > 64'(OUT_MAX)) ? OUT_MAX : plain_w[OUT_BITS-1:0];
	assign ssum_out  = (ssum_w > 64'(OUT_MAX)) ? OUT_MAX : ssum_w[OUT_BITS-1:0];
	// clamped operands give the same saturated total as the full-width sums
	assign total_add = {1'b0, plain_out} + {1'b0, ssum_out};

	assign res_valid               = stage.go && it.last_in_block;
	assign res.block_stalled       = stall_new;
	assign res.cycles_without_stalls = plain_out;
	assign res.stall_cycles        = ssum_out;
	assign res.total_cycles        = total_add[OUT_BITS] ? OUT_MAX : total_add[OUT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mask_q <= '0;
			cur_mask_q  <= '0;
			stall_q     <= 1'b0;
			plain_q     <= '0;
			stall_sum_q <= '0;
		end else if (stage.go) begin
			if (it.last_in_block) begin
				prev_mask_q <= cur_new;
				cur_mask_q  <= '0;
				stall_q     <= 1'b0;
				plain_q     <= plain_new;
				stall_sum_q <= ssum_new;
			end else begin
				cur_mask_q  <= cur_new;
				stall_q     <= stall_new;
				plain_q     <= base_plain;
				stall_sum_q <= base_ssum;
				prev_mask_q <= base_prev;
			end
		end
	end

endmodule

>>> src/lusc_out_reg.sv
module lusc_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_valid,
	input  lusc_pkg::lusc_out_t res,
	output logic                out_free,
	output logic                result_valid,
	input  logic                result_ready,
	output lusc_pkg::lusc_out_t result
);
	import lusc_pkg::*;

	logic      out_valid_q;
	lusc_out_t out_q;

	assign out_free     = !out_valid_q || result_ready;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			out_q <= res;
		end
	end

endmodule

>>> src/load_use_stall_counter.sv
// Load-use stall counter. Takes one instruction transaction per cycle unless
// a block end waits on a held output, and gives one result transaction at
// each block end, carrying the stall flag of that block and the saturating
// running totals. An accepted instruction is held in the input register and
// its result is registered in the output register; the mask test and the
// counter update sit in the combinational logic between the two, so the
// sustained rate is one instruction per cycle while results are taken. A
// stalled output holds back only block-ending instructions.
module load_use_stall_counter #(
	parameter int NUM_REGS     = lusc_pkg::LUSC_NUM_REGS,
	parameter int MAX_OPERANDS = lusc_pkg::LUSC_MAX_OPERANDS,
	parameter int COUNT_BITS   = lusc_pkg::LUSC_COUNT_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  lusc_pkg::lusc_in_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output lusc_pkg::lusc_out_t result
);
	import lusc_pkg::*;

	lusc_stage_t stage;
	logic        out_free;
	logic        res_valid;
	lusc_out_t   res;

	lusc_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.out_free   (out_free),
		.stage      (stage)
	);

	lusc_core #(
		.NUM_REGS     (NUM_REGS),
		.MAX_OPERANDS (MAX_OPERANDS),
		.COUNT_BITS   (COUNT_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.stage     (stage),
		.res_valid (res_valid),
		.res       (res)
	);

	lusc_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res          (res),
		.out_free     (out_free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !res_valid)
		else $error("result overwritten while held");

	a_stall_le_plain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.stall_cycles <= result.cycles_without_stalls)
		else $error("stall total exceeds cycle total");

	a_total_ge_plain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.total_cycles >= result.cycles_without_stalls)
		else $error("total below cycle total");

	a_res_needs_go: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> stage.go && stage.item.last_in_block)
		else $error("result without block end");

endmodule

>>> tb/load_use_stall_checker.sv
module load_use_stall_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_ready,
	input  lusc_pkg::lusc_in_t  item,
	input  logic                result_valid,
	input  logic                result_ready,
	input  lusc_pkg::lusc_out_t result,
	output int                  mismatches,
	output int                  pending_totals,
	output int                  blocks_checked,
	output int                  stalls_checked
);
	import lusc_pkg::*;

	localparam logic [63:0] SUM_LIMIT = {64{1'b1}} >> (64 - LUSC_COUNT_BITS);
	localparam logic [63:0] OUT_LIMIT = {{(64 - OUT_BITS){1'b0}}, OUT_MAX};

	logic [LUSC_NUM_REGS-1:0] prior_loads = '0;
	logic [LUSC_NUM_REGS-1:0] block_loads = '0;
	logic                     block_hit   = 1'b0;
	logic [63:0]              base_sum    = '0;
	logic [63:0]              hazard_sum  = '0;
	lusc_out_t                expected_totals[$];

	function automatic logic [63:0] clamp_add(input logic [63:0] a, input logic [63:0] b,
			input logic [63:0] lim);
		logic [63:0] s;
		s = a + b;
		if (s < a || s > lim)
			return lim;
		return s;
	endfunction

	task automatic clear_run();
		prior_loads = '0;
		block_loads = '0;
		block_hit   = 1'b0;
		base_sum    = '0;
		hazard_sum  = '0;
	endtask

	task automatic apply_instr(input lusc_in_t ins);
		int          n;
		logic [4:0]  regs [0:2];
		lusc_out_t   totals;
		logic [63:0] rep;
		logic [63:0] total_w;
		if (ins.start_of_run)
			clear_run();
		n = int'(ins.operand_count);
		if (n > LUSC_MAX_OPERANDS)
			n = LUSC_MAX_OPERANDS;
		regs[0] = ins.operand_a;
		regs[1] = ins.operand_b;
		regs[2] = ins.operand_c;
		for (int i = 0; i < n && i < 3; i++) begin
			if (regs[i] < LUSC_NUM_REGS) begin
				if (!ins.is_memory && prior_loads[regs[i]])
					block_hit = 1'b1;
				if (ins.is_load)
					block_loads[regs[i]] = 1'b1;
			end
		end
		if (!ins.last_in_block)
			return;
		rep = {32'd0, ins.block_repeat};
		base_sum = clamp_add(base_sum, rep, SUM_LIMIT);
		if (block_hit)
			hazard_sum = clamp_add(hazard_sum, rep, SUM_LIMIT);
		total_w = clamp_add(base_sum, hazard_sum, OUT_LIMIT);
		totals.block_stalled         = block_hit;
		totals.cycles_without_stalls = base_sum > OUT_LIMIT ? OUT_MAX : base_sum[OUT_BITS-1:0];
		totals.stall_cycles          = hazard_sum > OUT_LIMIT ? OUT_MAX : hazard_sum[OUT_BITS-1:0];
		totals.total_cycles          = total_w[OUT_BITS-1:0];
		expected_totals.insert(expected_totals.size(), totals);
		prior_loads = block_loads;
		block_loads = '0;
		block_hit   = 1'b0;
	endtask

	task automatic compare_totals(input lusc_out_t want, input lusc_out_t got);
		if (got.block_stalled !== want.block_stalled) begin
			$error("block_stalled: expected %0d, got %0d", want.block_stalled, got.block_stalled);
			mismatches++;
		end
		if (got.cycles_without_stalls !== want.cycles_without_stalls) begin
			$error("cycles_without_stalls: expected %0d, got %0d",
				want.cycles_without_stalls, got.cycles_without_stalls);
			mismatches++;
		end
		if (got.stall_cycles !== want.stall_cycles) begin
			$error("stall_cycles: expected %0d, got %0d", want.stall_cycles, got.stall_cycles);
			mismatches++;
		end
		if (got.total_cycles !== want.total_cycles) begin
			$error("total_cycles: expected %0d, got %0d", want.total_cycles, got.total_cycles);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_run();
			expected_totals.delete();
			pending_totals = 0;
		end else begin
			if (result_valid === 1'b1 && result_ready === 1'b1) begin
				if (expected_totals.size() == 0) begin
					$error("result transaction with no block end waiting");
					mismatches++;
				end else begin
					compare_totals(expected_totals.pop_front(), result);
					blocks_checked++;
					if (result.block_stalled)
						stalls_checked++;
				end
			end
			if (item_valid === 1'b1 && item_ready === 1'b1)
				apply_instr(item);
			pending_totals = expected_totals.size();
		end
	end

endmodule

>>> tb/load_use_stall_counter_tb.sv
module load_use_stall_counter_tb;
	import lusc_pkg::*;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	logic      item_ready;
	lusc_in_t  item         = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	lusc_out_t result;

	int mismatches;
	int pending_totals;
	int blocks_checked;
	int stalls_checked;

	int idle_pct  = 33;
	int hold_left = 0;
	int instr_sent = 0;

	always #1 clk = ~clk;

	load_use_stall_counter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	load_use_stall_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.item           (item),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.result         (result),
		.mismatches     (mismatches),
		.pending_totals (pending_totals),
		.blocks_checked (blocks_checked),
		.stalls_checked (stalls_checked)
	);

	// result side: random backpressure, or a counted hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				result_ready <= 1'b0;
			end else if (hold_left > 0) begin
				result_ready <= 1'b0;
				hold_left--;
			end else begin
				result_ready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	function automatic lusc_in_t make_instr(input bit start, input bit ld, input bit mem,
			input int cnt, input int a, input int b, input int c,
			input logic [31:0] rep, input bit last);
		lusc_in_t ins;
		ins.start_of_run  = start;
		ins.is_load       = ld;
		ins.is_memory     = mem;
		ins.operand_count = cnt[CNT_BITS-1:0];
		ins.operand_a     = a[OPND_BITS-1:0];
		ins.operand_b     = b[OPND_BITS-1:0];
		ins.operand_c     = c[OPND_BITS-1:0];
		ins.block_repeat  = rep;
		ins.last_in_block = last;
		return ins;
	endfunction

	// register numbers lean on a small set so that load-use hits are common
	function automatic int pick_reg();
		return ($urandom_range(99) < 70) ? $urandom_range(0, 7) : $urandom_range(0, 31);
	endfunction

	function automatic lusc_in_t random_instr();
		lusc_in_t    ins;
		logic [31:0] rep;
		ins = '0;
		ins.is_load       = ($urandom_range(99) < 35);
		ins.is_memory     = ins.is_load ? ($urandom_range(99) < 90) : ($urandom_range(99) < 20);
		ins.operand_count = CNT_BITS'($urandom_range(0, 3));
		ins.operand_a     = OPND_BITS'(pick_reg());
		ins.operand_b     = OPND_BITS'(pick_reg());
		ins.operand_c     = OPND_BITS'(pick_reg());
		case ($urandom_range(0, 4))
			0: rep = $urandom_range(0, 100);
			1: rep = 32'hFFFF_FFFF;
			2: rep = 32'd0;
			default: rep = $urandom;
		endcase
		ins.block_repeat = rep;
		return ins;
	endfunction

	// called right after a rising edge; returns right after the accepting edge
	task automatic push_instr(input lusc_in_t ins);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= ins;
		@(posedge clk);
		while (item_ready !== 1'b1)
			@(posedge clk);
		instr_sent++;
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		@(negedge clk);
		wait (pending_totals == 0);
		@(posedge clk);
	endtask

	task automatic send_block(input bit restart);
		lusc_in_t ins;
		int       len;
		int       restart_at;
		len        = $urandom_range(1, 5);
		restart_at = restart ? $urandom_range(0, len - 1) : -1;
		for (int k = 0; k < len; k++) begin
			ins               = random_instr();
			ins.start_of_run  = (k == restart_at);
			ins.last_in_block = (k == len - 1);
			push_instr(ins);
		end
	endtask

	task automatic send_noise();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		push_instr(raw[$bits(lusc_in_t)-1:0]);
	endtask

	initial begin
		#2000000;
		$display("load_use_stall_counter_tb NOT OK");
		$finish;
	end

	initial begin
		lusc_in_t ins;
		bit       held;
		bit       paused;
		held   = 1'b0;
		paused = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, operand count limits, store vs load, flags, restarts
		push_instr(make_instr(1, 1, 1, 3, 0, 31, 5, 32'd0, 1));
		push_instr(make_instr(0, 0, 0, 1, 31, 0, 0, 32'd5, 0));
		push_instr(make_instr(0, 1, 0, 2, 7, 8, 0, 32'hFFFF_FFFF, 1));
		push_instr(make_instr(0, 1, 1, 3, 1, 2, 3, 32'd1, 1));
		push_instr(make_instr(0, 1, 1, 3, 4, 5, 6, 32'd0, 0));
		push_instr(make_instr(0, 0, 0, 0, 1, 2, 3, 32'd2, 1));
		push_instr(make_instr(0, 0, 0, 1, 9, 4, 4, 32'd3, 0));
		push_instr(make_instr(0, 0, 0, 2, 9, 10, 6, 32'd3, 0));
		push_instr(make_instr(0, 1, 1, 3, 11, 12, 13, 32'd3, 1));
		push_instr(make_instr(0, 0, 1, 3, 11, 12, 13, 32'd4, 0));
		push_instr(make_instr(0, 0, 0, 3, 0, 0, 13, 32'd4, 1));
		push_instr(make_instr(0, 1, 0, 1, 20, 0, 0, 32'd6, 0));
		push_instr(make_instr(1, 0, 0, 0, 0, 0, 0, 32'd7, 1));
		push_instr(make_instr(0, 1, 0, 3, 20, 21, 22, 32'd0, 1));
		push_instr(make_instr(0, 1, 0, 1, 22, 0, 0, 32'd1, 1));
		push_instr(make_instr(0, 0, 0, 3, 31, 30, 29, 32'hFFFF_FFFF, 1));

		while (instr_sent < 1580) begin
			idle_pct = (instr_sent >= 500 && instr_sent < 800) ? 0 : 33;
			if (!held && instr_sent >= 1000) begin
				// result side stalls while single-instruction blocks keep coming
				held      = 1'b1;
				hold_left = 80;
				repeat (40) begin
					ins               = random_instr();
					ins.last_in_block = 1'b1;
					push_instr(ins);
				end
			end
			if (!paused && instr_sent >= 1300) begin
				paused = 1'b1;
				drain_results();
			end
			if ($urandom_range(99) < 10)
				send_noise();
			else
				send_block($urandom_range(99) < 4);
		end

		repeat (20)
			send_block(1'b0);
		send_block(1'b1);

		drain_results();
		repeat (10) @(posedge clk);
		$display("Sent %0d instructions: directed cases, random blocks with noise and restarts,",
			instr_sent);
		$display("a long result hold-off; %0d block totals checked, %0d of them stalled.",
			blocks_checked, stalls_checked);
		if (mismatches == 0) begin
			$display("load_use_stall_counter_tb OK");
		end else begin
			$display("load_use_stall_counter_tb NOT OK");
		end
		$finish;
	end

endmodule
